### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for concurrent assertions on clk with asynchronous reset arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define DPQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define DPQ_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

### rtl/dpq_pkg.sv
// ----------------------------------------------------------------------------
// Dot product package
// Widths, codes, types and helpers shared by the packed dot product block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dpq_pkg;

	// Sizes of the query store and the document stream.
	localparam int MAX_DOC_BYTES = 4096;
	localparam int NUM_LANES     = 4;
	localparam int QUERY_DEPTH   = NUM_LANES * MAX_DOC_BYTES;
	localparam int LEN_W         = $clog2(MAX_DOC_BYTES) + 1;
	localparam int POS_W         = $clog2(MAX_DOC_BYTES);
	localparam int ADDR_W        = 14;
	localparam int QV_W          = 4;
	localparam int DV_W          = 2;
	localparam int DOC_W         = NUM_LANES * DV_W;
	localparam int PROD_W        = QV_W + DV_W;
	localparam int PSUM_W        = PROD_W + $clog2(NUM_LANES);
	localparam int SCORE_W       = 20;
	localparam int CNT_W         = 16;
	localparam int RESET_LEN     = 16;

	// Request kinds.
	localparam logic KIND_QUERY = 1'b0;
	localparam logic KIND_DOC   = 1'b1;

	// Control that travels with a document byte down the pipeline.
	typedef struct packed {
		logic vld;
		logic last;
	} ctl_t;

	typedef logic [NUM_LANES-1:0][PROD_W-1:0] prod_vec_t;

	// Clamp a programmed length into 1..MAX_DOC_BYTES.
	function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
		logic [LEN_W-1:0] r;
		if (v == '0) begin
			r = LEN_W'(1);
		end else if (v > LEN_W'(MAX_DOC_BYTES)) begin
			r = LEN_W'(MAX_DOC_BYTES);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

### rtl/dpq_in_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying query writes and document bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dpq_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [13:0] query_address;
	logic [3:0]  query_value;
	logic [7:0]  doc_data;

	modport source (output valid, kind, query_address, query_value, doc_data,
		input ready);
	modport sink (input valid, kind, query_address, query_value, doc_data,
		output ready);
endinterface

### rtl/dpq_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one score per document.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dpq_out_if;
	logic        valid;
	logic        ready;
	logic [19:0] score;
	logic [15:0] doc_number;

	modport source (output valid, score, doc_number, input ready);
	modport sink (input valid, score, doc_number, output ready);
endinterface

### rtl/dpq_lane.sv
// ----------------------------------------------------------------------------
// Dot product lane
// Holds a full copy of the query and multiplies one 2-bit document value
// by the query entry of its stripe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpq_lane
	import dpq_pkg::*;
(
	input  logic              clk,
	input  logic              en_s1,
	input  logic              en_s2,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [QV_W-1:0]   wdata,
	input  logic [ADDR_W-1:0] raddr,
	input  logic [DV_W-1:0]   dval,
	output logic [PROD_W-1:0] prod_s2
);

	logic [QV_W-1:0] store_q [QUERY_DEPTH];
	logic [QV_W-1:0] qv_s1;
	logic [DV_W-1:0] dv_s1;

	// Query copy: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			store_q[waddr] <= wdata;
		end
		if (en_s1) begin
			qv_s1 <= store_q[raddr];
			dv_s1 <= dval;
		end
	end

	// Product of the document value and the query entry.
	always_ff @(posedge clk) begin
		if (en_s2) begin
			prod_s2 <= PROD_W'(dv_s1) * PROD_W'(qv_s1);
		end
	end

endmodule

### rtl/dpq_merge.sv
// ----------------------------------------------------------------------------
// Dot product merge
// Adds the lane products into the running sum and emits the score with
// the document number at the end of each document.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpq_merge
	import dpq_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clr,
	input  ctl_t          ctl_s2,
	input  prod_vec_t     prod_s2,
	output logic          retire,
	dpq_out_if.source     result
);

	logic                 out_v_q;
	logic [SCORE_W-1:0]   acc_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [SCORE_W-1:0]   score_q;
	logic [CNT_W-1:0]     docnum_q;
	logic [PSUM_W-1:0]    psum;
	logic [SCORE_W-1:0]   acc_next;
	logic                 out_free;

	// Sum of the four lane products and the updated running sum.
	always_comb begin
		psum = '0;
		for (int e = 0; e < NUM_LANES; e++) begin
			psum = psum + PSUM_W'(prod_s2[e]);
		end
		acc_next = acc_q + SCORE_W'(psum);
	end

	// A byte that ends a document needs room in the output register.
	assign out_free = !out_v_q || result.ready;
	assign retire   = ctl_s2.vld && (!ctl_s2.last || out_free);

	// Running sum, document counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			acc_q   <= '0;
			cnt_q   <= '0;
		end else begin
			if (clr) begin
				acc_q <= '0;
			end else if (retire) begin
				acc_q <= ctl_s2.last ? '0 : acc_next;
			end
			if (retire && ctl_s2.last) begin
				out_v_q <= 1'b1;
				cnt_q   <= cnt_q + CNT_W'(1);
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (retire && ctl_s2.last) begin
			score_q  <= acc_next;
			docnum_q <= cnt_q;
		end
	end

	assign result.valid      = out_v_q;
	assign result.score      = score_q;
	assign result.doc_number = docnum_q;

endmodule

### rtl/packed_2bit_4bit_dot_product.sv
// ----------------------------------------------------------------------------
// Packed 2-bit by 4-bit dot product
// Scores streamed documents of packed 2-bit values against a 4-bit query
// held in four lane copies, one lane per value position in the byte.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle, query writes and document bytes alike.
// A finished score held on the result channel stalls requests once both
// pipeline stages behind it are full.
// The lane store read and the lane multiply are the two stages before the
// score register. Reset clears the byte position, running sum and document
// counter and sets the length to 16; the query store is undefined until written.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module packed_2bit_4bit_dot_product
	import dpq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [LEN_W-1:0]  cfg_wdata,
	dpq_in_if.sink            item,
	dpq_out_if.source         result
);

	logic [LEN_W-1:0]                 len_q;
	logic [LEN_W-1:0]                 new_len;
	logic [NUM_LANES-1:0][ADDR_W-1:0] base_q;
	logic [POS_W-1:0]                 pos_q;
	logic                             accept;
	logic                             doc_acc;
	logic                             qry_we;
	logic                             last_byte;
	logic                             en_s1;
	logic                             en_s2;
	logic                             retire;
	ctl_t                             ctl_s1;
	ctl_t                             ctl_s2;
	prod_vec_t                        prod_s2;

	// Handshake and pipeline advance.
	assign accept    = item.valid && item.ready;
	assign doc_acc   = accept && (item.kind == KIND_DOC);
	assign qry_we    = accept && (item.kind == KIND_QUERY);
	assign en_s2     = !ctl_s2.vld || retire;
	assign en_s1     = !ctl_s1.vld || en_s2;
	assign item.ready = en_s1;
	assign last_byte = ({1'b0, pos_q} == (len_q - LEN_W'(1)));
	assign new_len   = eff_len(cfg_wdata);

	// Length, stripe bases and byte position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_W'(RESET_LEN);
			pos_q <= '0;
			for (int e = 0; e < NUM_LANES; e++) begin
				base_q[e] <= ADDR_W'(e * RESET_LEN);
			end
		end else if (cfg_we) begin
			len_q <= new_len;
			pos_q <= '0;
			for (int e = 0; e < NUM_LANES; e++) begin
				base_q[e] <= ADDR_W'(ADDR_W'(new_len) * ADDR_W'(e));
			end
		end else if (doc_acc) begin
			pos_q <= last_byte ? '0 : pos_q + POS_W'(1);
		end
	end

	// Pipeline control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			if (en_s1) begin
				ctl_s1 <= '{vld: doc_acc, last: last_byte};
			end
			if (en_s2) begin
				ctl_s2 <= ctl_s1;
			end
		end
	end

	// One lane per value position; lane 0 takes bits 7:6.
	for (genvar e = 0; e < NUM_LANES; e++) begin : g_lane
		dpq_lane u_lane (
			.clk     (clk),
			.en_s1   (en_s1),
			.en_s2   (en_s2),
			.we      (qry_we),
			.waddr   (item.query_address),
			.wdata   (item.query_value),
			.raddr   (base_q[e] + ADDR_W'(pos_q)),
			.dval    (item.doc_data[DOC_W-1-DV_W*e -: DV_W]),
			.prod_s2 (prod_s2[e])
		);
	end

	dpq_merge u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (cfg_we),
		.ctl_s2  (ctl_s2),
		.prod_s2 (prod_s2),
		.retire  (retire),
		.result  (result)
	);

	// Checks on position tracking and back-pressure.
	`DPQ_ASSERT(a_pos_in_range, ({1'b0, pos_q} < len_q), "byte position beyond length")
	`DPQ_ASSERT(a_stall_cause, (!item.ready |-> (ctl_s1.vld && ctl_s2.vld && ctl_s2.last && result.valid && !result.ready)), "stall without a held result")
	`DPQ_ASSERT(a_cfg_restart, (cfg_we |=> (pos_q == '0)), "length write did not restart the document")

endmodule
